>>> design/lph_pkg.sv
// Shared constants and types for the linear-probe hash table core.
// No dependencies; lph_front, lph_back, the core top and the testbench refer to it by scoped name.
package lph_pkg;

   localparam int TABLE_SLOTS_DEFAULT = 16;
   localparam int QUEUE_DEPTH_DEFAULT = 2;

   localparam int KEY_W     = 32;
   localparam int STATUS_W  = 2;
   localparam int SLOT_W    = 4;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_SEARCH = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_INSERTED = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FOUND    = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_MISSING  = 2'd3;

   typedef enum logic [1:0] {
      BACK_CLEAR,
      BACK_IDLE,
      BACK_PROBE
   } back_state_type;

   typedef struct packed {
      logic                done;
      logic                write;
      logic [STATUS_W-1:0] status;
   } probe_result_type;

endpackage

>>> design/lph_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing; read data holds while no read is issued.
module lph_ram #(
   parameter int WIDTH = 33,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/lph_front.sv
// Front end: accepts requests and reduces the key to its home slot with a
// reciprocal multiply and then one correcting subtract. Uses lph_pkg.
module lph_front #(
   parameter int TABLE_SLOTS = lph_pkg::TABLE_SLOTS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               clearing,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_op,
   input  logic [lph_pkg::KEY_W-1:0]          req_key,
   output logic                               push_valid,
   input  logic                               push_ready,
   output logic [$clog2(TABLE_SLOTS)+lph_pkg::KEY_W:0] push_data
);

   localparam int AW     = $clog2(TABLE_SLOTS);
   localparam int KW     = lph_pkg::KEY_W;
   localparam int STEPS  = 2;
   localparam int STEP_W = $clog2(STEPS + 1);
   localparam logic [2*KW-1:0] RECIP_WIDE = (64'd1 << KW) / 64'(TABLE_SLOTS);
   localparam logic [KW-1:0]   RECIP      = RECIP_WIDE[KW-1:0];

   logic                      busy_ff, busy_in;
   logic [STEP_W-1:0]         step_ff, step_in;
   logic                      op_ff, op_in;
   logic [KW-1:0]             key_ff, key_in;
   logic [AW:0]               qlo_ff, qlo_in;
   logic [AW-1:0]             rem_ff, rem_in;
   logic [AW-1:0]             rem_next;
   logic [2*KW-1:0]           product;
   logic                      accept;
   logic                      working;

   assign req_ready  = !busy_ff && !clearing;
   assign accept     = req_valid && req_ready;
   assign working    = busy_ff && (step_ff != STEP_W'(STEPS));
   assign push_valid = busy_ff && (step_ff == STEP_W'(STEPS));
   assign push_data  = {rem_ff, key_ff, op_ff};
   assign product    = {{KW{1'b0}}, key_ff} * {{KW{1'b0}}, RECIP};

   always_comb begin
      logic [AW:0] raw;
      raw = key_ff[AW:0] - qlo_ff * (AW+1)'(TABLE_SLOTS);
      if (raw >= (AW+1)'(TABLE_SLOTS)) begin
         raw = raw - (AW+1)'(TABLE_SLOTS);
      end
      rem_next = raw[AW-1:0];
   end

   always_comb begin
      busy_in  = busy_ff;
      step_in  = step_ff;
      op_in    = op_ff;
      key_in   = key_ff;
      qlo_in   = qlo_ff;
      rem_in   = rem_ff;
      if (accept) begin
         busy_in  = 1'b1;
         step_in  = '0;
         op_in    = req_op;
         key_in   = req_key;
      end else if (working) begin
         step_in  = step_ff + STEP_W'(1);
         qlo_in   = product[KW+AW:KW];
         rem_in   = rem_next;
      end else if (push_valid && push_ready) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
      op_ff    <= op_in;
      key_ff   <= key_in;
      qlo_ff   <= qlo_in;
      rem_ff   <= rem_in;
   end

endmodule

>>> design/lph_queue.sv
// Short FIFO between the front end and the probe engine.
// Depends on nothing; width and depth come from the parent.
module lph_queue #(
   parameter int WIDTH = 37,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entries_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0]    count_ff;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != CW'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entries_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
      return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= bump(wr_ptr_ff);
         end
         if (do_pop) begin
            rd_ptr_ff <= bump(rd_ptr_ff);
         end
         unique case ({do_push, do_pop})
            2'b10:   count_ff <= count_ff + CW'(1);
            2'b01:   count_ff <= count_ff - CW'(1);
            default: count_ff <= count_ff;
         endcase
      end
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> design/lph_back.sv
// Probe engine: clears the slot store after reset, then walks the probe
// sequence one slot per cycle. Uses lph_pkg and lph_ram.
module lph_back #(
   parameter int TABLE_SLOTS = lph_pkg::TABLE_SLOTS_DEFAULT
) (
   input  logic                                         clock,
   input  logic                                         reset,
   output logic                                         clearing,
   input  logic                                         pop_valid,
   output logic                                         pop_ready,
   input  logic [$clog2(TABLE_SLOTS)+lph_pkg::KEY_W:0]  pop_data,
   output logic                                         rsp_valid,
   input  logic                                         rsp_ready,
   output logic [lph_pkg::STATUS_W-1:0]                 rsp_status,
   output logic [lph_pkg::SLOT_W-1:0]                   rsp_slot
);

   localparam int AW = $clog2(TABLE_SLOTS);
   localparam int KW = lph_pkg::KEY_W;
   localparam int RW = KW + 1;

   lph_pkg::back_state_type state_ff, state_in;

   logic [AW-1:0]  addr_ff, addr_in;
   logic [AW-1:0]  count_ff, count_in;
   logic           op_ff, op_in;
   logic [KW-1:0]  key_ff, key_in;
   logic [AW-1:0]  clear_ff, clear_in;

   logic                          out_valid_ff, out_valid_in;
   logic [lph_pkg::STATUS_W-1:0]  out_status_ff, out_status_in;
   logic [lph_pkg::SLOT_W-1:0]    out_slot_ff, out_slot_in;

   logic           ram_wr_en, ram_rd_en;
   logic [AW-1:0]  ram_wr_addr, ram_rd_addr;
   logic [RW-1:0]  ram_wr_data, ram_rd_data;

   logic                    slot_used, key_match, last_probe, out_free;
   logic [AW-1:0]           addr_next;
   logic [AW+3:0]           slot_wide;
   logic [AW-1:0]           pop_home;
   logic                    pop_op;
   logic [KW-1:0]           pop_key;
   lph_pkg::probe_result_type probe;

   lph_ram #(
      .WIDTH (RW),
      .DEPTH (TABLE_SLOTS)
   ) u_slots (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign pop_op     = pop_data[0];
   assign pop_key    = pop_data[KW:1];
   assign pop_home   = pop_data[AW+KW:KW+1];
   assign slot_used  = ram_rd_data[KW];
   assign key_match  = (ram_rd_data[KW-1:0] == key_ff);
   assign last_probe = (count_ff == AW'(TABLE_SLOTS - 1));
   assign addr_next  = (addr_ff == AW'(TABLE_SLOTS - 1)) ? '0 : addr_ff + AW'(1);
   assign slot_wide  = {4'b0000, addr_ff};
   assign out_free   = !out_valid_ff || rsp_ready;
   assign clearing   = (state_ff == lph_pkg::BACK_CLEAR);

   always_comb begin
      probe = '{done: 1'b0, write: 1'b0, status: lph_pkg::STATUS_MISSING};
      if (op_ff == lph_pkg::OP_INSERT) begin
         priority if (!slot_used) begin
            probe = '{done: 1'b1, write: 1'b1, status: lph_pkg::STATUS_INSERTED};
         end else if (last_probe) begin
            probe = '{done: 1'b1, write: 1'b0, status: lph_pkg::STATUS_FULL};
         end else begin
            probe = '{done: 1'b0, write: 1'b0, status: lph_pkg::STATUS_FULL};
         end
      end else begin
         priority if (!slot_used) begin
            probe = '{done: 1'b1, write: 1'b0, status: lph_pkg::STATUS_MISSING};
         end else if (key_match) begin
            probe = '{done: 1'b1, write: 1'b0, status: lph_pkg::STATUS_FOUND};
         end else if (last_probe) begin
            probe = '{done: 1'b1, write: 1'b0, status: lph_pkg::STATUS_MISSING};
         end else begin
            probe = '{done: 1'b0, write: 1'b0, status: lph_pkg::STATUS_MISSING};
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lph_pkg::BACK_CLEAR: begin
            if (clear_ff == AW'(TABLE_SLOTS - 1)) begin
               state_in = lph_pkg::BACK_IDLE;
            end
         end
         lph_pkg::BACK_IDLE: begin
            if (pop_valid) begin
               state_in = lph_pkg::BACK_PROBE;
            end
         end
         lph_pkg::BACK_PROBE: begin
            if (probe.done && out_free) begin
               state_in = lph_pkg::BACK_IDLE;
            end
         end
         default: state_in = lph_pkg::BACK_CLEAR;
      endcase
   end

   always_comb begin
      addr_in       = addr_ff;
      count_in      = count_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      clear_in      = clear_ff;
      pop_ready     = 1'b0;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = addr_ff;
      ram_wr_data   = {1'b1, key_ff};
      ram_rd_en     = 1'b0;
      ram_rd_addr   = addr_next;
      out_valid_in  = out_valid_ff && !rsp_ready;
      out_status_in = out_status_ff;
      out_slot_in   = out_slot_ff;
      unique case (state_ff)
         lph_pkg::BACK_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clear_ff;
            ram_wr_data = '0;
            clear_in    = clear_ff + AW'(1);
         end
         lph_pkg::BACK_IDLE: begin
            pop_ready   = 1'b1;
            ram_rd_addr = pop_home;
            if (pop_valid) begin
               ram_rd_en = 1'b1;
               addr_in   = pop_home;
               count_in  = '0;
               op_in     = pop_op;
               key_in    = pop_key;
            end
         end
         lph_pkg::BACK_PROBE: begin
            if (!probe.done) begin
               ram_rd_en = 1'b1;
               addr_in   = addr_next;
               count_in  = count_ff + AW'(1);
            end else if (out_free) begin
               ram_wr_en     = probe.write;
               out_valid_in  = 1'b1;
               out_status_in = probe.status;
               out_slot_in   = (probe.status == lph_pkg::STATUS_INSERTED ||
                                probe.status == lph_pkg::STATUS_FOUND) ?
                               slot_wide[3:0] : '0;
            end
         end
         default: begin
            clear_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lph_pkg::BACK_CLEAR;
         clear_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clear_ff     <= clear_in;
         out_valid_ff <= out_valid_in;
      end
      addr_ff       <= addr_in;
      count_ff      <= count_in;
      op_ff         <= op_in;
      key_ff        <= key_in;
      out_status_ff <= out_status_in;
      out_slot_ff   <= out_slot_in;
   end

   assign rsp_valid  = out_valid_ff;
   assign rsp_status = out_status_ff;
   assign rsp_slot   = out_slot_ff;

endmodule

>>> design/linear_probe_hash_table_core.sv
// Open-addressing hash table of 32-bit keys with linear probing. Each request
// (insert or search) gives one response with a status and a slot index. After
// reset the slot store is cleared, with req_tready low. The front end reduces
// a key to its home slot (a reciprocal multiply, then one correcting subtract)
// and queues it, and takes no new request until the current one is queued; the
// probe engine then probes 1 to TABLE_SLOTS slots per request, one slot RAM
// read per cycle. Home-slot reduction of the next request overlaps the probing
// of the current one. A finished response waits in an output register.
// Depends on lph_pkg, lph_front, lph_queue, lph_back and lph_ram.
module linear_probe_hash_table_core #(
   parameter int TABLE_SLOTS = lph_pkg::TABLE_SLOTS_DEFAULT,
   parameter int QUEUE_DEPTH = lph_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] key
   input  logic [0:0]  req_tuser,   // [0] operation
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [3:0] slot, [7:4] zero
   output logic [1:0]  rsp_tuser    // [1:0] status
);

   localparam int AW = $clog2(TABLE_SLOTS);
   localparam int QW = AW + lph_pkg::KEY_W + 1;

   logic          clearing;
   logic          front_valid, front_ready;
   logic [QW-1:0] front_data;
   logic          queue_valid, queue_ready;
   logic [QW-1:0] queue_data;
   logic [lph_pkg::SLOT_W-1:0] slot;

   lph_front #(
      .TABLE_SLOTS (TABLE_SLOTS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .clearing   (clearing),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_op     (req_tuser[0]),
      .req_key    (req_tdata),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_data  (front_data)
   );

   lph_queue #(
      .WIDTH (QW),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_data  (front_data),
      .pop_valid  (queue_valid),
      .pop_ready  (queue_ready),
      .pop_data   (queue_data)
   );

   lph_back #(
      .TABLE_SLOTS (TABLE_SLOTS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .clearing   (clearing),
      .pop_valid  (queue_valid),
      .pop_ready  (queue_ready),
      .pop_data   (queue_data),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_status (rsp_tuser),
      .rsp_slot   (slot)
   );

   assign rsp_tdata = {4'b0000, slot};

endmodule

>>> test/lph_checker.sv
// Checker for the linear-probe hash table core: watches both stream channels,
// predicts each response from its own copy of the table and compares fields.
// Depends on lph_pkg for widths, operation and status codes.
module lph_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] key
   input  logic [0:0]  req_tuser,   // [0] operation
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [7:0]  rsp_tdata,   // [3:0] slot, [7:4] zero
   input  logic [1:0]  rsp_tuser,   // [1:0] status
   output int          mismatch_count,
   output int          pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SLOTS = lph_pkg::TABLE_SLOTS_DEFAULT;

   typedef struct packed {
      logic [lph_pkg::STATUS_W-1:0] status;
      logic [lph_pkg::SLOT_W-1:0]   slot;
   } probe_outcome_type;

   probe_outcome_type expected_outcomes[$];
   logic [lph_pkg::KEY_W-1:0] shadow_keys [SLOTS];
   logic                      shadow_used [SLOTS];

   initial begin
      mismatch_count = 0;
      pending_count  = 0;
      for (int i = 0; i < SLOTS; i++) begin
         shadow_used[i] = 1'b0;
         shadow_keys[i] = '0;
      end
   end

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      $display("[%0t] mismatch: %s", $time, msg);
   endtask

   task automatic probe_table(input logic op, input logic [31:0] key,
                              output probe_outcome_type outcome);
      int idx;
      bit done;
      idx  = int'(key % 32'(SLOTS));
      done = 1'b0;
      outcome.slot   = '0;
      outcome.status = (op == lph_pkg::OP_INSERT) ? lph_pkg::STATUS_FULL
                                                  : lph_pkg::STATUS_MISSING;
      for (int i = 0; i < SLOTS; i++) begin
         if (!done) begin
            if (op == lph_pkg::OP_INSERT) begin
               if (!shadow_used[idx]) begin
                  shadow_used[idx] = 1'b1;
                  shadow_keys[idx] = key;
                  outcome.status   = lph_pkg::STATUS_INSERTED;
                  outcome.slot     = idx[lph_pkg::SLOT_W-1:0];
                  done             = 1'b1;
               end
            end else begin
               if (!shadow_used[idx]) begin
                  done = 1'b1;
               end else if (shadow_keys[idx] == key) begin
                  outcome.status = lph_pkg::STATUS_FOUND;
                  outcome.slot   = idx[lph_pkg::SLOT_W-1:0];
                  done           = 1'b1;
               end
            end
            idx = (idx + 1 == SLOTS) ? 0 : idx + 1;
         end
      end
   endtask

   always @(posedge clock) begin
      probe_outcome_type want;
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            shadow_used[i] = 1'b0;
         end
         expected_outcomes.delete();
      end else begin
         if (req_tvalid && req_tready) begin
            probe_table(req_tuser[0], req_tdata, want);
            expected_outcomes.push_back(want);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_outcomes.size() == 0) begin
               report_mismatch($sformatf("response status %0d slot %0d with no request open",
                                         rsp_tuser, rsp_tdata[3:0]));
            end else begin
               want = expected_outcomes.pop_front();
               if (rsp_tuser !== want.status) begin
                  report_mismatch($sformatf("status expected %0d got %0d",
                                            want.status, rsp_tuser));
               end
               if (rsp_tdata[3:0] !== want.slot) begin
                  report_mismatch($sformatf("slot expected %0d got %0d",
                                            want.slot, rsp_tdata[3:0]));
               end
               if (rsp_tdata[7:4] !== 4'd0) begin
                  report_mismatch($sformatf("tdata pad expected 0 got %0h",
                                            rsp_tdata[7:4]));
               end
            end
         end
      end
      pending_count = expected_outcomes.size();
   end

endmodule

>>> test/tb_top.sv
// Top of the hash table testbench: clock, reset, request stimulus and response
// back-pressure around linear_probe_hash_table_core, with lph_checker beside it.
// Depends on lph_pkg, the core and test/lph_checker.sv.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_REQUESTS = 1626;
   localparam int HOLD_AT         = 400;
   localparam int HOLD_CYCLES     = 300;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;   // [31:0] key
   logic [0:0]  req_tuser;   // [0] operation
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [7:0]  rsp_tdata;   // [3:0] slot, [7:4] zero
   logic [1:0]  rsp_tuser;   // [1:0] status

   int mismatch_count;
   int pending_count;
   int requests_sent = 0;
   int inserts_sent  = 0;
   int searches_sent = 0;
   int hold_left     = 0;
   bit hold_done     = 1'b0;
   bit steady_phase  = 1'b0;

   logic [31:0] inserted_keys[$];

   always #5 clock = ~clock;

   linear_probe_hash_table_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   lph_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   function automatic logic [31:0] key_with_home(input int home);
      logic [31:0] key;
      key      = $urandom;
      key[3:0] = home[3:0];
      return key;
   endfunction

   task automatic send_request(input logic op, input logic [31:0] key);
      if (!steady_phase && $urandom_range(0, 99) < 11) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= key;
      do @(posedge clock); while (!req_tready);
      requests_sent++;
      if (op == lph_pkg::OP_INSERT) begin
         inserts_sent++;
         inserted_keys.push_back(key);
      end else begin
         searches_sent++;
      end
      @(negedge clock);
   endtask

   // receiver: random stalls outside the steady phase, one long hold-off once traffic is flowing
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (!hold_done && requests_sent >= HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else if (steady_phase) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= 11);
         end
      end
   end

   initial begin
      #5_000_000;
      $display("FAILED: results differ");
      $finish;
   end

   initial begin
      int pick;
      int choice;
      logic [31:0] key;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty table, extremes, wrap-around and duplicates
      send_request(lph_pkg::OP_SEARCH, 32'h0000_0000);
      send_request(lph_pkg::OP_INSERT, 32'hFFFF_FFFF);
      send_request(lph_pkg::OP_INSERT, 32'h0000_000F);
      send_request(lph_pkg::OP_INSERT, 32'hFFFF_FFFF);
      send_request(lph_pkg::OP_SEARCH, 32'hFFFF_FFFF);
      send_request(lph_pkg::OP_SEARCH, 32'h0000_000F);
      send_request(lph_pkg::OP_SEARCH, key_with_home(15));
      send_request(lph_pkg::OP_INSERT, 32'h0000_0000);
      send_request(lph_pkg::OP_SEARCH, 32'h0000_0000);
      // fill the rest of the table
      for (int i = 0; i < 12; i++) begin
         send_request(lph_pkg::OP_INSERT, key_with_home($urandom_range(0, 15)));
      end
      send_request(lph_pkg::OP_INSERT, 32'h8000_0000);
      send_request(lph_pkg::OP_SEARCH, 32'h7FFF_FFF0);
      send_request(lph_pkg::OP_SEARCH, inserted_keys[inserted_keys.size() - 1]);

      for (int n = 0; n < RANDOM_REQUESTS; n++) begin
         steady_phase = (n >= 700 && n < 1000);
         choice = $urandom_range(0, 99);
         pick   = $urandom_range(0, inserted_keys.size() - 1);
         if (choice < 45) begin
            send_request(lph_pkg::OP_SEARCH, inserted_keys[pick]);
         end else if (choice < 70) begin
            send_request(lph_pkg::OP_SEARCH, $urandom);
         end else if (choice < 80) begin
            key = inserted_keys[pick] ^ (32'd1 << $urandom_range(0, 31));
            send_request(lph_pkg::OP_SEARCH, key);
         end else begin
            send_request(lph_pkg::OP_INSERT, $urandom);
         end
      end
      steady_phase = 1'b0;
      req_tvalid <= 1'b0;

      do @(negedge clock); while (pending_count != 0);
      repeat (40) @(negedge clock);

      $display("Covered %0d requests (%0d inserts, %0d searches) on a table filled to full,",
               requests_sent, inserts_sent, searches_sent);
      $display("with collisions, wrap-around, duplicates, full inserts and a long output stall.");
      if (mismatch_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
